[hdl/rsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_pkg: shared definitions for the reorderable shift queue
// Sizes, operation codes, the per-cell command and the control bundle that
// the decoder broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DIST_W     = 5;
    localparam int CFG_W      = 5;
    localparam int CMP_W      = (CNT_W > DIST_W) ? CNT_W : DIST_W;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        KIND_ENQ     = 2'd0,
        KIND_DEQ     = 2'd1,
        KIND_PROMOTE = 2'd2,
        KIND_DEMOTE  = 2'd3
    } kind_t;

    // What each cell does this cycle.
    //   LOAD: the cell at pos_a takes the input word.
    //   FWD:  cells below pos_a take their upper neighbor, pos_a takes the head.
    //   BACK: pos_a takes the tail, cells above pos_a up to pos_b take their
    //         lower neighbor.
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_FWD  = 2'd2,
        CMD_BACK = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [IDX_W-1:0] pos_a;
        logic [IDX_W-1:0] pos_b;
    } cell_ctl_t;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] count_next;
        logic             full_next;
        logic [IDX_W-1:0] tail_idx;
    } op_res_t;

endpackage
`default_nettype wire

[hdl/rsq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_cell: one storage cell of the queue
// Holds one word and picks its next value from its neighbors, the head, the
// tail or the input word according to the broadcast command.
// ----------------------------------------------------------------------------
module rsq_cell
    import rsq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [IDX_W-1:0]      cell_idx,
    input  wire cell_ctl_t             ctl,
    input  wire logic [DATA_WIDTH-1:0] in_word,
    input  wire logic [DATA_WIDTH-1:0] head_word,
    input  wire logic [DATA_WIDTH-1:0] tail_word,
    input  wire logic [DATA_WIDTH-1:0] prev_word,
    input  wire logic [DATA_WIDTH-1:0] next_word,
    output logic      [DATA_WIDTH-1:0] q,
    output logic      [DATA_WIDTH-1:0] d_next
);

    logic [DATA_WIDTH-1:0] data_reg;

    always_comb
    begin
        d_next = data_reg;
        case (ctl.cmd)
            CMD_HOLD:
            begin
                d_next = data_reg;
            end
            CMD_LOAD:
            begin
                if (cell_idx == ctl.pos_a)
                    d_next = in_word;
            end
            CMD_FWD:
            begin
                if (cell_idx < ctl.pos_a)
                    d_next = next_word;
                else if (cell_idx == ctl.pos_a)
                    d_next = head_word;
            end
            CMD_BACK:
            begin
                if (cell_idx == ctl.pos_a)
                    d_next = tail_word;
                else if (cell_idx > ctl.pos_a && cell_idx <= ctl.pos_b)
                    d_next = prev_word;
            end
            default:
            begin
                d_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= d_next;
    end

    assign q = data_reg;

endmodule
`default_nettype wire

[hdl/rsq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsq_ctrl: operation decoder
// Checks whether an operation may run and turns it into the cell command,
// the move boundaries and the new occupancy.
// ----------------------------------------------------------------------------
module rsq_ctrl
    import rsq_pkg::*;
(
    input  wire logic              fire,
    input  wire logic [1:0]        kind,
    input  wire logic [DIST_W-1:0] distance,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [CFG_W-1:0]  capacity,
    output cell_ctl_t              ctl,
    output op_res_t                res
);

    logic [CNT_W-1:0] cap_eff;
    logic [CMP_W-1:0] dist_ext;
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] span;
    logic [CNT_W-1:0] last;
    logic             move_ok;

    always_comb
    begin
        if (capacity == '0)
            cap_eff = CNT_W'(1);
        else if (int'(capacity) > DEPTH)
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = CNT_W'(capacity);
    end

    assign last     = count - CNT_W'(1);
    assign dist_ext = CMP_W'(distance);
    assign lim      = CMP_W'(last);
    assign span     = (dist_ext < lim) ? dist_ext : lim;
    assign move_ok  = (distance != '0) && (count >= CNT_W'(2));

    always_comb
    begin
        ctl.cmd        = CMD_HOLD;
        ctl.pos_a      = '0;
        ctl.pos_b      = IDX_W'(last);
        res.ok         = 1'b0;
        res.count_next = count;
        case (kind_t'(kind))
            KIND_ENQ:
            begin
                res.ok    = (count < cap_eff);
                ctl.cmd   = CMD_LOAD;
                ctl.pos_a = IDX_W'(count);
                if (res.ok)
                    res.count_next = count + CNT_W'(1);
            end
            KIND_DEQ:
            begin
                res.ok    = (count != '0);
                ctl.cmd   = CMD_FWD;
                ctl.pos_a = IDX_W'(last);
                if (res.ok)
                    res.count_next = last;
            end
            KIND_PROMOTE:
            begin
                res.ok    = move_ok;
                ctl.cmd   = CMD_BACK;
                ctl.pos_a = IDX_W'(lim - span);
            end
            KIND_DEMOTE:
            begin
                res.ok    = move_ok;
                ctl.cmd   = CMD_FWD;
                ctl.pos_a = IDX_W'(span);
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
        if (!(fire && res.ok))
            ctl.cmd = CMD_HOLD;
        res.full_next = (res.count_next >= cap_eff);
        res.tail_idx  = IDX_W'(last);
    end

endmodule
`default_nettype wire

[hdl/reorderable_shift_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reorderable_shift_queue_unit: FIFO of words in a chain of shifting cells
// Enqueue, dequeue, promote-tail and demote-head on a queue of up to 16 words.
// ----------------------------------------------------------------------------
// Usage: an operation beat enters on in_valid/in_ready carrying kind,
// item_value and distance. Every operation beat yields exactly one result
// beat on out_valid/out_ready: ok, the dequeued word, the new head word, the
// occupancy and the empty and full flags after the operation.
// Within an operation, the decoder and every cell's select logic work on the
// current queue contents in the same cycle, all cells load at the accepting
// edge, and the result is captured in an output register at that same edge.
// One operation per cycle is sustained while the receiver takes results;
// the rate is set by the cell update plus one output register.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken, so no beat is ever lost or reordered.
// Reset empties the queue (the cell contents are not cleared, only the
// occupancy count) and sets the capacity register to 16. The capacity is
// written through cfg_we/cfg_data; the user must write it only while idle, as the block does not enforce
// this; 0 acts as 1 and values above 16 act as 16.
// ----------------------------------------------------------------------------
module reorderable_shift_queue_unit
    import rsq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        kind,
    input  wire logic [31:0]       item_value,
    input  wire logic [DIST_W-1:0] distance,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   ok,
    output logic [31:0]            removed_value,
    output logic [31:0]            head_value,
    output logic [4:0]             occupancy,
    output logic                   is_empty,
    output logic                   is_full
);

    logic [CFG_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  out_valid_reg;
    logic                  ok_reg;
    logic [31:0]           removed_reg;
    logic [31:0]           head_reg;
    logic [4:0]            occ_reg;
    logic                  empty_reg;
    logic                  full_reg;

    logic                  fire;
    cell_ctl_t             ctl;
    op_res_t               res;
    logic [DATA_WIDTH-1:0] cell_q    [DEPTH];
    logic [DATA_WIDTH-1:0] cell_next [DEPTH];
    logic [DATA_WIDTH-1:0] in_word;
    logic [DATA_WIDTH-1:0] tail_word;
    logic [31:0]           head_next;
    logic [31:0]           removed_next;

    // A new beat is taken whenever the output register is free or being
    // emptied in the same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign in_word  = DATA_WIDTH'(item_value);

    // The tail word is broadcast to the chain for promote.
    assign tail_word = cell_q[res.tail_idx];

    rsq_ctrl u_ctrl (
        .fire     (fire),
        .kind     (kind),
        .distance (distance),
        .count    (count_reg),
        .capacity (cap_reg),
        .ctl      (ctl),
        .res      (res)
    );

    // The cell chain: entry 0 is the head. Each cell sees its two neighbors;
    // the ends get a zero word that is never selected.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_prev
            assign prev_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_next
            assign next_w = cell_q[i+1];
        end

        rsq_cell u_cell (
            .clk       (clk),
            .cell_idx  (IDX_W'(i)),
            .ctl       (ctl),
            .in_word   (in_word),
            .head_word (cell_q[0]),
            .tail_word (tail_word),
            .prev_word (prev_w),
            .next_word (next_w),
            .q         (cell_q[i]),
            .d_next    (cell_next[i])
        );
    end

    // Result fields describe the queue after the operation, so the head
    // comes from the head cell's next value.
    assign head_next    = (res.count_next != '0) ? 32'(cell_next[0]) : 32'd0;
    assign removed_next = (res.ok && kind_t'(kind) == KIND_DEQ) ? 32'(cell_q[0]) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (fire)
                count_reg <= res.count_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg      <= res.ok;
            removed_reg <= removed_next;
            head_reg    <= head_next;
            occ_reg     <= 5'(res.count_next);
            empty_reg   <= (res.count_next == '0);
            full_reg    <= res.full_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign removed_value = removed_reg;
    assign head_value    = head_reg;
    assign occupancy     = occ_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule
`default_nettype wire
